/* rtl/core/rat_pkg.sv */
// Shared types and constants for the rational accumulator core.
// Holds the operation codes, the sequencer states and the datapath widths.
// Depends on nothing; every core module imports it.
package rat_pkg;

    localparam int WIDTH = 32;
    localparam int MAG_W = WIDTH;
    localparam int PROD_W = 2 * MAG_W;
    localparam int MUL_CNT_W = $clog2(MAG_W);
    localparam int DIV_CNT_W = $clog2(PROD_W);

    typedef enum logic [2:0] {
        KIND_LOAD = 3'd0,
        KIND_ADD  = 3'd1,
        KIND_SUB  = 3'd2,
        KIND_MUL  = 3'd3,
        KIND_DIV  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* rtl/core/rat_mul.sv */
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on rat_pkg for the operand and product widths.
module rat_mul import rat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAG_W-1:0]    i_a,
    input  logic [MAG_W-1:0]    i_b,
    output logic [PROD_W-1:0]   o_prod,
    output logic                o_done
);
    logic [MAG_W-1:0]     r_a;
    logic [MAG_W-1:0]     r_b;
    logic [PROD_W-1:0]    r_prod;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MAG_W:0]       n_sum;

    // add the multiplicand into the upper half, then shift right one bit
    assign n_sum = {1'b0, r_prod[PROD_W-1:MAG_W]} + {1'b0, (r_b[0] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_prod <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= {n_sum, r_prod[MAG_W-1:1]};
                r_b    <= {1'b0, r_b[MAG_W-1:1]};
                r_cnt  <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_prod;
    assign o_done = r_done;
endmodule

/* rtl/core/rat_gcd.sv */
// Binary gcd unit: one shift or one subtract per cycle on 64-bit values.
// Depends on rat_pkg for the product width.
module rat_gcd import rat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_x,
    input  logic [PROD_W-1:0]   i_y,
    output logic [PROD_W-1:0]   o_gcd,
    output logic                o_done
);
    logic [PROD_W-1:0]    r_x;
    logic [PROD_W-1:0]    r_y;
    logic [PROD_W-1:0]    r_g;
    logic [DIV_CNT_W-1:0] r_k;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x == '0) begin
                    r_g    <= r_y << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_y == '0) begin
                    r_g    <= r_x << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + DIV_CNT_W'(1);
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_gcd  = r_g;
    assign o_done = r_done;
endmodule

/* rtl/core/rat_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on rat_pkg for the product width.
module rat_div import rat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_num,
    input  logic [PROD_W-1:0]   i_den,
    output logic [PROD_W-1:0]   o_quot,
    output logic                o_done
);
    logic [PROD_W-1:0]    r_q;
    logic [PROD_W:0]      r_rem;
    logic [PROD_W-1:0]    r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PROD_W:0]      n_sh;
    logic                 n_fit;

    assign n_sh  = {r_rem[PROD_W-1:0], r_q[PROD_W-1]};
    assign n_fit = n_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_d    <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_fit ? (n_sh - {1'b0, r_d}) : n_sh;
                r_q   <= {r_q[PROD_W-2:0], n_fit};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

/* rtl/core/rational_accumulator_alu_core.sv */
// Top level of the rational accumulator: sequencer, sign handling, result word.
// Depends on rat_pkg, rat_mul, rat_gcd and rat_div.
//
// Usage:
// - Input channel: i_valid / o_stall carry one word (kind, operand fraction).
//   A word is taken at a rising edge with i_valid high and o_stall low.
// - Output channel: o_valid / i_stall carry one result word per input word.
// - Each word runs through three bit-serial multipliers in parallel, a sign
//   add, a binary gcd (one shift or subtract per cycle) and two bit-serial
//   dividers in parallel, plus sequencing. Only the gcd loop varies in
//   length with the operands; a zero denominator skips gcd and division.
// - One word is in flight at a time; o_stall is high from accept until the
//   result is moved into the output register, so the next word can be taken
//   in the cycle after that move.
// - The output register holds a finished word while the receiver stalls,
//   so the next input word may be taken meanwhile; it finishes and waits.
// - Reset (synchronous, active low) sets the accumulator to 0/1 and
//   empties the output register.
module rational_accumulator_alu_core import rat_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_kind,
    input  logic signed [WIDTH-1:0] i_operand_num,
    input  logic signed [WIDTH-1:0] i_operand_den,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [WIDTH-1:0] o_result_num,
    output logic [WIDTH-2:0]        o_result_den,
    output logic                    o_is_whole,
    output logic                    o_is_undefined,
    output logic                    o_overflowed
);
    t_state r_state, n_state;

    // accumulator
    logic [WIDTH-1:0] r_acc_num;
    logic [WIDTH-2:0] r_acc_den;

    // per-word signs and sums
    logic              r_n0n, r_n1n, r_en, r_nn, r_undef;
    logic [PROD_W-1:0] r_nm, r_em;
    logic              r_gcd_go;

    // output register
    logic              r_o_valid;
    logic [WIDTH-1:0]  r_o_num;
    logic [WIDTH-2:0]  r_o_den;
    logic              r_o_whole, r_o_undef, r_o_ovf;

    logic              accept_in, out_free;
    logic              mul_start, gcd_start, div_start;
    logic [MAG_W-1:0]  a0, b0, a1, b1, a2, b2;
    logic              n0n, n1n, en;
    logic [PROD_W-1:0] p0, p1, p2, gcd_val, qn, qe;
    logic              m0_done, m1_done, m2_done, g_done, dn_done, de_done;
    logic [MAG_W-1:0]  am, bm, cm, dm;
    logic              an, cn, dn;
    logic [PROD_W-1:0] sum_m;
    logic              sum_n;

    // final shaping
    logic              f_neg, f_ovf, f_undef;
    logic [PROD_W-1:0] f_sv;
    logic [WIDTH-1:0]  f_num;
    logic [WIDTH-2:0]  f_den;

    assign accept_in = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;

    // sign-magnitude split of accumulator and operand
    assign an = r_acc_num[WIDTH-1];
    assign am = an ? (MAG_W'(0) - r_acc_num) : r_acc_num;
    assign bm = {1'b0, r_acc_den};
    assign cn = i_operand_num[WIDTH-1];
    assign cm = cn ? (MAG_W'(0) - i_operand_num) : i_operand_num;
    assign dn = i_operand_den[WIDTH-1];
    assign dm = dn ? (MAG_W'(0) - i_operand_den) : i_operand_den;

    // route magnitudes into the three multipliers; unused lanes multiply zero
    always_comb begin
        a0 = am; b0 = dm; a1 = '0; b1 = '0; a2 = bm; b2 = cm;
        n0n = an ^ dn; n1n = 1'b0; en = cn;
        case (i_kind)
            KIND_LOAD: begin
                a0 = cm; b0 = MAG_W'(1); n0n = cn;
                a2 = dm; b2 = MAG_W'(1); en = dn;
            end
            KIND_ADD, KIND_SUB: begin
                a1 = cm; b1 = bm; n1n = cn ^ (i_kind == KIND_SUB);
                a2 = bm; b2 = dm; en = dn;
            end
            KIND_MUL: begin
                a0 = am; b0 = cm; n0n = an ^ cn;
                a2 = bm; b2 = dm; en = dn;
            end
            default: begin
                // divide, and the undefined kinds behave as divide
            end
        endcase
    end

    // signed sum of the two numerator products
    always_comb begin
        if (r_n0n == r_n1n) begin
            sum_m = p0 + p1;
            sum_n = r_n0n;
        end else if (p0 >= p1) begin
            sum_m = p0 - p1;
            sum_n = r_n0n;
        end else begin
            sum_m = p1 - p0;
            sum_n = r_n1n;
        end
    end

    // move the sign onto the reduced quotients, flag overflow and undefined, cut to width
    always_comb begin
        f_neg = (qn != '0) && (r_nn != r_en);
        f_ovf = (qe[PROD_W-1:WIDTH-1] != '0) ||
                (f_neg ? (qn > (PROD_W'(1) << (WIDTH-1)))
                       : (qn > ((PROD_W'(1) << (WIDTH-1)) - PROD_W'(1))));
        f_sv  = f_neg ? (PROD_W'(0) - qn) : qn;
        f_num = f_sv[WIDTH-1:0];
        f_den = qe[WIDTH-2:0];
        f_undef = r_undef || (f_den == '0);
        if (r_undef) begin
            f_ovf = 1'b0;
        end
        if (f_undef) begin
            f_num = '0;
            f_den = '0;
        end
    end

    rat_mul u_mul0 (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(a0), .i_b(b0),
                    .o_prod(p0), .o_done(m0_done));
    rat_mul u_mul1 (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(a1), .i_b(b1),
                    .o_prod(p1), .o_done(m1_done));
    rat_mul u_mul2 (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(a2), .i_b(b2),
                    .o_prod(p2), .o_done(m2_done));

    rat_gcd u_gcd (.i_clk, .i_rst_n, .i_start(gcd_start), .i_x(r_nm), .i_y(r_em),
                   .o_gcd(gcd_val), .o_done(g_done));

    rat_div u_div_n (.i_clk, .i_rst_n, .i_start(div_start), .i_num(r_nm),
                     .i_den(gcd_val), .o_quot(qn), .o_done(dn_done));
    rat_div u_div_e (.i_clk, .i_rst_n, .i_start(div_start), .i_num(r_em),
                     .i_den(gcd_val), .o_quot(qe), .o_done(de_done));

    // sequencer: next state and unit starts
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        gcd_start = 1'b0;
        div_start = 1'b0;
        o_stall   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                if (m0_done && m1_done && m2_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // zero denominator skips reduction
                if (p2 == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // kick the gcd on the first cycle, once the sums are registered
                gcd_start = r_gcd_go;
                if (g_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (dn_done && de_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc_num <= '0;
            r_acc_den <= (WIDTH-1)'(1);
            r_o_valid <= 1'b0;
            r_gcd_go  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gcd_go <= (r_state == S_SUM) && (p2 != '0);
            if (accept_in) begin
                r_n0n <= n0n;
                r_n1n <= n1n;
                r_en  <= en;
            end
            if (r_state == S_SUM) begin
                r_nm    <= sum_m;
                r_nn    <= sum_n;
                r_em    <= p2;
                r_undef <= (p2 == '0);
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            // move the finished word out and update the accumulator
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
                r_o_num   <= f_num;
                r_o_den   <= f_den;
                r_o_whole <= (f_den == (WIDTH-1)'(1));
                r_o_undef <= f_undef;
                r_o_ovf   <= f_ovf;
                r_acc_num <= f_num;
                r_acc_den <= f_den;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_num   = r_o_num;
    assign o_result_den   = r_o_den;
    assign o_is_whole     = r_o_whole;
    assign o_is_undefined = r_o_undef;
    assign o_overflowed   = r_o_ovf;

    a_undef_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_undefined |-> o_result_num == '0 && o_result_den == '0)
        else $error("undefined result not shown as 0/0");

    a_den_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_undefined |-> o_result_den != '0)
        else $error("defined result with zero denominator");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while a word is in flight");

    a_gcd_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_done |=> gcd_val != '0)
        else $error("gcd of a nonzero denominator is zero");
endmodule

/* bench/rational_accumulator_alu_core_tb.sv */
// Testbench for rational_accumulator_alu_core: drives operation words with random gaps,
// predicts each reduced fraction and its flags, and checks every result word in order.
// Depends on rat_pkg and the core RTL.
`timescale 1ns / 1ps

module rational_accumulator_alu_core_tb;
    import rat_pkg::*;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               whole;
        logic               undef;
        logic               ovf;
    } t_frac_res;

    localparam int STALL_LIMIT = 20000;

    // Spare kind codes, handled as divide.
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_kind = '0;
    logic signed [31:0] i_operand_num = '0;
    logic signed [31:0] i_operand_den = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [31:0] o_result_num;
    logic [30:0]       o_result_den;
    logic              o_is_whole;
    logic              o_is_undefined;
    logic              o_overflowed;

    // Predictor copy of the accumulator.
    logic [31:0] acc_num_q;
    logic [31:0] acc_den_q;

    t_frac_res expected_fracs[$];
    int        mismatches = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        idle_cycles = 0;
    bit        timed_out = 1'b0;
    bit        rx_stall_on = 1'b1;

    rational_accumulator_alu_core i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Pick a gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] mag_of(input logic [31:0] x);
        logic [31:0] m;
        m = x[31] ? (32'd0 - x) : x;
        return {32'd0, m};
    endfunction

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Compute the reduced fraction for one word and advance the accumulator.
    function automatic t_frac_res reduce_fraction(input logic [2:0] kind,
                                                  input logic [31:0] cnum,
                                                  input logic [31:0] cden);
        logic [63:0] am, bm, cm, dm, nm, em, tm, pm, g, v;
        logic        an, bn, cn, dn, nn, en, tn, pn, neg;
        logic [63:0] nmax;
        t_frac_res   r;
        nmax = 64'd1 << (WIDTH - 1);
        am = mag_of(acc_num_q); an = acc_num_q[31];
        bm = mag_of(acc_den_q); bn = acc_den_q[31];
        cm = mag_of(cnum);      cn = cnum[31];
        dm = mag_of(cden);      dn = cden[31];
        r = '0;
        case (kind)
            KIND_LOAD: begin
                nm = cm; nn = cn; em = dm; en = dn;
            end
            KIND_ADD, KIND_SUB: begin
                tm = cm * bm; tn = cn != bn;
                if (kind == KIND_SUB) tn = !tn;
                pm = am * dm; pn = an != dn;
                if (pn == tn) begin
                    nn = pn; nm = pm + tm;
                end else if (pm >= tm) begin
                    nn = pn; nm = pm - tm;
                end else begin
                    nn = tn; nm = tm - pm;
                end
                em = bm * dm; en = bn != dn;
            end
            KIND_MUL: begin
                nm = am * cm; nn = an != cn;
                em = bm * dm; en = bn != dn;
            end
            default: begin
                // Unknown codes fall through to divide.
                nm = am * dm; nn = an != dn;
                em = bm * cm; en = bn != cn;
            end
        endcase
        if (em == 0) begin
            r.undef = 1'b1;
        end else begin
            g = euclid_gcd(nm, em);
            nm = nm / g;
            em = em / g;
            neg = (nm != 0) && (nn != en);
            if (em > nmax - 1 || (neg ? nm > nmax : nm > nmax - 1)) r.ovf = 1'b1;
            v = neg ? -nm : nm;
            r.num = v[31:0];
            r.den = em[30:0];
            if (r.den == 0) r.undef = 1'b1;
        end
        if (r.undef) begin
            r.num = '0;
            r.den = '0;
        end
        r.whole = (r.den == 31'd1);
        acc_num_q = r.num;
        acc_den_q = {1'b0, r.den};
        return r;
    endfunction

    // Send one word after a random gap; hold it until accepted.
    task automatic send_word(input logic [2:0] kind, input logic [31:0] n,
                             input logic [31:0] d);
        repeat (gap_len()) @(negedge i_clk);
        i_valid = 1'b1;
        i_kind = kind;
        i_operand_num = n;
        i_operand_den = d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_fracs.push_back(reduce_fraction(kind, n, d));
        words_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 20)) - 10);
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom();
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fff_ffff} ^ 32'($urandom_range(0, 3));
            4: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return 32'($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    // Receiver: stall at random, check each accepted result.
    always @(negedge i_clk) begin
        if (rx_stall_on && $urandom_range(0, 99) < 30) i_stall <= 1'b1;
        else i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_frac_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_fracs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word num=%0d den=%0d",
                                               o_result_num, o_result_den);
            end else begin
                want = expected_fracs.pop_front();
                words_checked++;
                if (o_result_num !== want.num || o_result_den !== want.den ||
                    o_is_whole !== want.whole || o_is_undefined !== want.undef ||
                    o_overflowed !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d w%0b u%0b o%0b, got %0d/%0d w%0b u%0b o%0b",
                                 want.num, want.den, want.whole, want.undef, want.ovf,
                                 o_result_num, o_result_den, o_is_whole, o_is_undefined,
                                 o_overflowed);
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rational_accumulator_alu_core verification failed");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_word(KIND_ADD, 32'd1, 32'd2);              // add to reset value 0/1
        send_word(KIND_LOAD, 32'h7fff_ffff, 32'd1);
        send_word(KIND_ADD, 32'd1, 32'd1);               // overflow of numerator
        send_word(KIND_LOAD, 32'h8000_0000, 32'd1);      // most negative
        send_word(KIND_MUL, 32'hffff_ffff, 32'd1);       // negate: overflow
        send_word(KIND_LOAD, 32'd6, 32'hffff_fffc);      // sign moves to numerator
        send_word(KIND_SUB, 32'd3, 32'd7);
        send_word(KIND_MUL, 32'd0, 32'd5);               // zero numerator -> 0/1
        send_word(KIND_LOAD, 32'd3, 32'd0);              // zero denominator
        send_word(KIND_ADD, 32'd1, 32'd2);               // stays undefined
        send_word(KIND_LOAD, 32'd0, 32'd0);              // 0/0
        send_word(KIND_LOAD, 32'd5, 32'd3);
        send_word(KIND_DIV, 32'd0, 32'd9);               // divide by zero
        send_word(KIND_LOAD, 32'd1, 32'h7fff_ffff);
        send_word(KIND_DIV, 32'd1, 32'd2);               // gives 2/(2^31-1), no overflow
        send_word(KIND_LOAD, 32'd1, 32'h8000_0000);      // denominator 2^31 overflows
        send_word(KIND_LOAD, 32'hffff_fff9, 32'd3);
        send_word(KIND_SPARE5, 32'd2, 32'd5);            // unknown codes act as divide
        send_word(KIND_SPARE6, 32'hffff_ffff, 32'd4);
        send_word(KIND_SPARE7, 32'd3, 32'hffff_fffe);
        send_word(KIND_LOAD, 32'd10, 32'd4);             // plain reduction
    endtask

    task automatic test_random_chains();
        logic [2:0] k;
        logic [31:0] d;
        int r;
        repeat (530) begin
            r = $urandom_range(0, 99);
            if (r < 15) k = KIND_LOAD;
            else if (r < 95) k = 3'($urandom_range(1, 4));
            else k = 3'($urandom_range(5, 7));
            d = rand_field();
            if (d == 0 && $urandom_range(0, 3) != 0) d = 32'd1;
            send_word(k, rand_field(), d);
        end
    endtask

    task automatic test_no_rx_stall();
        rx_stall_on = 1'b0;
        repeat (20) send_word(3'($urandom_range(0, 4)), rand_field(), rand_field());
        rx_stall_on = 1'b1;
    endtask

    initial begin
        acc_num_q = '0;
        acc_den_q = 32'd1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_extremes();
        test_random_chains();
        test_no_rx_stall();
        while (expected_fracs.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d words (all kinds, undefined, overflow, sign cases), checked %0d.",
                 words_sent, words_checked);
        if (mismatches == 0 && expected_fracs.size() == 0) begin
            $display("rational_accumulator_alu_core verification clean");
        end else begin
            $display("rational_accumulator_alu_core verification failed");
        end
        $finish;
    end

endmodule
